// ===== rtl/rca_pkg.sv =====
// ----------------------------------------------------------------------------
// rca_pkg
// Shared opcodes and defaults for the ring chunk allocator.
// ----------------------------------------------------------------------------
package rca_pkg;

   // default offset width in bits
   localparam int unsigned OFFSET_BITS_DEF = 24;

   // buffer size after reset, truncated to the register width at use
   localparam logic [63:0] BUFFER_BYTES_RESET = 64'd65536;

   // request opcodes
   typedef enum logic [1:0] {
      OP_PLACE  = 2'd0,
      OP_FREE   = 2'd1,
      OP_QUERY  = 2'd2,
      OP_UNUSED = 2'd3
   } opcode_type;

endpackage

// ===== rtl/rca_req_reg.sv =====
// ----------------------------------------------------------------------------
// rca_req_reg
// Input register: captures one request word and holds it until the core
// has moved it on to the response register.
// ----------------------------------------------------------------------------
module rca_req_reg #(
   parameter int unsigned OFFSET_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rca_pkg::opcode_type       req_opcode,
   input  logic [OFFSET_BITS:0]      req_chunk_size,
   input  logic [OFFSET_BITS:0]      req_free_end,
   input  logic                      take,
   output logic                      busy,
   output rca_pkg::opcode_type       opcode,
   output logic [OFFSET_BITS:0]      chunk_size,
   output logic [OFFSET_BITS:0]      free_end
);
   import rca_pkg::*;

   logic                 valid_ff, valid_in;
   opcode_type           opcode_ff;
   logic [OFFSET_BITS:0] size_ff;
   logic [OFFSET_BITS:0] fend_ff;

   // free when empty or when the held word leaves this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         opcode_ff <= req_opcode;
         size_ff   <= req_chunk_size;
         fend_ff   <= req_free_end;
      end
   end

   assign busy       = valid_ff;
   assign opcode     = opcode_ff;
   assign chunk_size = size_ff;
   assign free_end   = fend_ff;

endmodule

// ===== rtl/rca_core.sv =====
// ----------------------------------------------------------------------------
// rca_core
// Allocator state (write offset, read offset, wrap point, buffer size) and
// the fit decision for the word held in the input register.
// ----------------------------------------------------------------------------
module rca_core #(
   parameter int unsigned OFFSET_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [OFFSET_BITS:0]      csr_wr_data,
   input  logic                      commit,
   input  rca_pkg::opcode_type       opcode,
   input  logic [OFFSET_BITS:0]      chunk_size,
   input  logic [OFFSET_BITS:0]      free_end,
   output logic                      granted,
   output logic [OFFSET_BITS-1:0]    chunk_offset,
   output logic                      wrapped
);
   import rca_pkg::*;

   localparam int unsigned W = OFFSET_BITS + 1;
   localparam logic [W-1:0] BUF_RESET = BUFFER_BYTES_RESET[W-1:0];

   logic [W-1:0] buf_bytes_ff;
   logic [W-1:0] write_ff, write_in;
   logic [W-1:0] read_ff,  read_in;
   logic [W-1:0] wrap_ff,  wrap_in;

   logic         rd_le_wr, fits_end, fits_rd, wraps, ok;
   logic [W:0]   sum_wr, sum_cand;
   logic [W-1:0] cand, where;

   // size register, written whenever the enable is high
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_bytes_ff <= BUF_RESET;
      end else if (csr_wr_en) begin
         buf_bytes_ff <= csr_wr_data;
      end
   end

   // fit check
   always_comb begin
      rd_le_wr = (read_ff <= write_ff);
      sum_wr   = {1'b0, write_ff} + {1'b0, chunk_size};
      fits_end = (sum_wr <= {1'b0, buf_bytes_ff});
      cand     = rd_le_wr ? '0 : write_ff;
      sum_cand = {1'b0, cand} + {1'b0, chunk_size};
      fits_rd  = (sum_cand < {1'b0, read_ff});
      wraps    = rd_le_wr && !fits_end;
      ok       = (rd_le_wr && fits_end) || fits_rd;
      if (rd_le_wr && fits_end) begin
         where = write_ff;
      end else if (fits_rd) begin
         where = cand;
      end else begin
         where = '0;
      end
   end

   // response and next state
   always_comb begin
      granted      = 1'b0;
      chunk_offset = '0;
      wrapped      = 1'b0;
      write_in     = write_ff;
      read_in      = read_ff;
      wrap_in      = wrap_ff;
      unique case (opcode)
         OP_PLACE, OP_QUERY: begin
            if (ok) begin
               granted      = 1'b1;
               chunk_offset = where[OFFSET_BITS-1:0];
               wrapped      = wraps;
               if (opcode == OP_PLACE) begin
                  if (wraps) begin
                     wrap_in  = write_ff;
                     write_in = chunk_size;
                  end else begin
                     write_in = sum_wr[W-1:0];
                  end
               end
            end
         end
         OP_FREE: begin
            granted = 1'b1;
            read_in = (free_end == wrap_ff) ? '0 : free_end;
         end
         default: begin
         end
      endcase
   end

   // state registers, updated as the word moves to the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         write_ff <= '0;
         read_ff  <= '0;
         wrap_ff  <= BUF_RESET;
      end else if (commit) begin
         write_ff <= write_in;
         read_ff  <= read_in;
         wrap_ff  <= wrap_in;
      end
   end

endmodule

// ===== rtl/rca_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// rca_rsp_reg
// Response register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module rca_rsp_reg #(
   parameter int unsigned OFFSET_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   output logic                      space,
   input  logic                      granted,
   input  logic [OFFSET_BITS-1:0]    chunk_offset,
   input  logic                      wrapped,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_granted,
   output logic [OFFSET_BITS-1:0]    rsp_chunk_offset,
   output logic                      rsp_wrapped
);
   import rca_pkg::*;

   logic                   valid_ff, valid_in;
   logic                   granted_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic                   wrapped_ff;

   // room when empty or when the held word is taken this cycle
   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         granted_ff <= granted;
         offset_ff  <= chunk_offset;
         wrapped_ff <= wrapped;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_granted      = granted_ff;
   assign rsp_chunk_offset = offset_ff;
   assign rsp_wrapped      = wrapped_ff;

endmodule

// ===== rtl/ring_chunk_allocator_top.sv =====
// ----------------------------------------------------------------------------
// ring_chunk_allocator_top
// Hands out contiguous chunk offsets in a ring buffer; place, query, free.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  request   | req_valid / req_ready | req_opcode, req_chunk_size, req_free_end
//  response  | rsp_valid / rsp_ready | rsp_granted, rsp_chunk_offset, rsp_wrapped
//  csr       | csr_wr_en (no wait)   | csr_wr_data (buffer size in bytes)
//
//  One request per cycle while req_ready is high; an accepted word is loaded into the
//  input register and moves on to the response register once that register has space.
//  The fit check and the state update sit between those two registers.
//  Synchronous reset clears both stages and sets the wrap point to the size.
//  A stalled response holds the input register, which then holds req_ready low.
// ----------------------------------------------------------------------------
module ring_chunk_allocator_top #(
   parameter int unsigned OFFSET_BITS = rca_pkg::OFFSET_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [OFFSET_BITS:0]      csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rca_pkg::opcode_type       req_opcode,
   input  logic [OFFSET_BITS:0]      req_chunk_size,
   input  logic [OFFSET_BITS:0]      req_free_end,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_granted,
   output logic [OFFSET_BITS-1:0]    rsp_chunk_offset,
   output logic                      rsp_wrapped
);
   import rca_pkg::*;

   logic                   busy, space, advance;
   opcode_type             opcode;
   logic [OFFSET_BITS:0]   chunk_size, free_end;
   logic                   granted, wrapped;
   logic [OFFSET_BITS-1:0] chunk_offset;

   // word moves from input register to response register
   assign advance = busy && space;

   rca_req_reg #(.OFFSET_BITS(OFFSET_BITS)) u_req (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_chunk_size (req_chunk_size),
      .req_free_end   (req_free_end),
      .take           (advance),
      .busy           (busy),
      .opcode         (opcode),
      .chunk_size     (chunk_size),
      .free_end       (free_end)
   );

   rca_core #(.OFFSET_BITS(OFFSET_BITS)) u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .commit       (advance),
      .opcode       (opcode),
      .chunk_size   (chunk_size),
      .free_end     (free_end),
      .granted      (granted),
      .chunk_offset (chunk_offset),
      .wrapped      (wrapped)
   );

   rca_rsp_reg #(.OFFSET_BITS(OFFSET_BITS)) u_rsp (
      .clock            (clock),
      .reset            (reset),
      .load             (advance),
      .space            (space),
      .granted          (granted),
      .chunk_offset     (chunk_offset),
      .wrapped          (wrapped),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_chunk_offset (rsp_chunk_offset),
      .rsp_wrapped      (rsp_wrapped)
   );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// ring chunk allocator testbench
// Drives place, query and free words through the request channel and checks
// every response against a cycle-free allocator predictor kept in the bench.
// Covers the fit and wrap rules, the top-of-buffer offset, register extremes,
// long random traffic with both sides idling, and a long response stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import rca_pkg::*;

   localparam int unsigned OB = OFFSET_BITS_DEF;
   localparam int unsigned QUIET_LIMIT = 2000;

   typedef logic [OB:0] wide_type;

   // expected response fields
   typedef struct packed {
      logic          granted;
      logic [OB-1:0] chunk_offset;
      logic          wrapped;
   } grant_word_type;

   localparam wide_type DEFAULT_BYTES = BUFFER_BYTES_RESET[OB:0];
   localparam wide_type TOP_BYTES     = wide_type'(1) << OB;
   localparam wide_type MAX_BYTES     = '1;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   wide_type      csr_wr_data = '0;
   logic          req_valid = 1'b0;
   logic          req_ready;
   opcode_type    req_opcode = OP_PLACE;
   wide_type      req_chunk_size = '0;
   wide_type      req_free_end = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_granted;
   logic [OB-1:0] rsp_chunk_offset;
   logic          rsp_wrapped;

   // allocator state as the bench predicts it
   wide_type model_buf_bytes = DEFAULT_BYTES;
   wide_type model_write_off = '0;
   wide_type model_read_off  = '0;
   wide_type model_wrap_point = DEFAULT_BYTES;

   grant_word_type expected_grants[$];
   grant_word_type want_grant;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned rsp_hold_cycles = 0;

   ring_chunk_allocator_top #(.OFFSET_BITS(OB)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_chunk_size   (req_chunk_size),
      .req_free_end     (req_free_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_chunk_offset (rsp_chunk_offset),
      .rsp_wrapped      (rsp_wrapped)
   );

   always #5 clock = ~clock;

   // fit check and state update for one accepted word
   function automatic grant_word_type predict_allocation(opcode_type op, wide_type size,
                                                         wide_type fend);
      grant_word_type res;
      wide_type       cand;
      wide_type       spot;
      logic           fits;
      logic           wraps;
      res   = '0;
      cand  = model_write_off;
      spot  = '0;
      fits  = 1'b0;
      wraps = 1'b0;
      if (op == OP_PLACE || op == OP_QUERY) begin
         // chunk goes at the write offset, or wraps to zero
         if (model_read_off <= model_write_off) begin
            if ({1'b0, model_write_off} + {1'b0, size} <= {1'b0, model_buf_bytes}) begin
               spot = model_write_off;
               fits = 1'b1;
            end else begin
               cand  = '0;
               wraps = 1'b1;
            end
         end
         // must end strictly below the read offset
         if (!fits && ({1'b0, cand} + {1'b0, size} < {1'b0, model_read_off})) begin
            spot = cand;
            fits = 1'b1;
         end
         if (fits) begin
            if (op == OP_PLACE) begin
               if (wraps) begin
                  model_wrap_point = model_write_off;
                  model_write_off  = '0;
               end
               model_write_off = model_write_off + size;
            end
            res.granted      = 1'b1;
            res.chunk_offset = spot[OB-1:0];
            res.wrapped      = wraps;
         end
      end else if (op == OP_FREE) begin
         // read offset returns to zero only on an exact hit of the wrap point
         model_read_off = fend;
         if (model_read_off == model_wrap_point)
            model_read_off = '0;
         res.granted = 1'b1;
      end
      return res;
   endfunction

   // chunk sizes that land on the fit boundaries half of the time
   function automatic wide_type pick_chunk_size();
      int unsigned choice;
      int unsigned hi;
      wide_type    size;
      choice = $urandom_range(0, 9);
      hi     = 32'(model_buf_bytes >> 2);
      if (hi < 1)
         hi = 1;
      case (choice)
         0: size = '0;
         1: begin
            if (model_read_off > model_write_off)
               size = model_read_off - model_write_off - wide_type'(1);
            else if (model_buf_bytes >= model_write_off)
               size = model_buf_bytes - model_write_off;
            else
               size = '0;
         end
         2: size = (model_read_off != '0) ? model_read_off - wide_type'(1) : '0;
         3: size = model_read_off;
         4: size = model_buf_bytes;
         default: size = wide_type'($urandom_range(1, hi));
      endcase
      return size;
   endfunction

   // frees that walk the read offset forward like a consumer would
   function automatic wide_type pick_free_end();
      int unsigned choice;
      wide_type    fend;
      choice = $urandom_range(0, 99);
      if (model_read_off > model_write_off) begin
         if (choice < 50 || model_wrap_point <= model_read_off)
            fend = model_wrap_point;
         else
            fend = wide_type'($urandom_range(32'(model_read_off), 32'(model_wrap_point)));
      end else begin
         if (choice < 70)
            fend = wide_type'($urandom_range(32'(model_read_off), 32'(model_write_off)));
         else if (choice < 85)
            fend = model_write_off;
         else
            fend = model_wrap_point;
      end
      return fend;
   endfunction

   function automatic wide_type pick_buffer_size();
      int unsigned choice;
      choice = $urandom_range(0, 99);
      if (choice < 70)
         return wide_type'($urandom_range(8, 600));
      else if (choice < 90)
         return wide_type'($urandom_range(601, 70000));
      return wide_type'($urandom_range(70001, 32'(MAX_BYTES)));
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // one request word, with a random gap ahead of it
   task automatic send_word(opcode_type op, wide_type size, wide_type fend);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_chunk_size <= size;
      req_free_end   <= fend;
      do
         @(posedge clock);
      while (!req_ready);
      expected_grants.push_back(predict_allocation(op, size, fend));
   endtask

   task automatic send_random_word();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         send_word(OP_PLACE, pick_chunk_size(), wide_type'($urandom));
      else if (pick < 60)
         send_word(OP_QUERY, pick_chunk_size(), wide_type'($urandom));
      else if (pick < 90)
         send_word(OP_FREE, wide_type'($urandom), pick_free_end());
      else
         send_word(opcode_type'($urandom_range(0, 3)), wide_type'($urandom),
                   wide_type'($urandom));
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (expected_grants.size() != 0)
         @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_buffer_size(wide_type bytes);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= bytes;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_buf_bytes = bytes;
   endtask

   // fit, wrap and free rules starting from the reset state
   task automatic test_fit_rules_at_reset();
      send_word(OP_UNUSED, MAX_BYTES, MAX_BYTES);
      send_word(OP_QUERY, '0, '0);
      send_word(OP_QUERY, DEFAULT_BYTES, '0);
      send_word(OP_QUERY, DEFAULT_BYTES + wide_type'(1), '0);
      send_word(OP_PLACE, DEFAULT_BYTES, '0);
      send_word(OP_PLACE, '0, '0);
      send_word(OP_PLACE, wide_type'(1), '0);
      send_word(OP_FREE, '0, wide_type'(100));
      send_word(OP_QUERY, wide_type'(50), '0);
      send_word(OP_QUERY, wide_type'(100), '0);
      send_word(OP_PLACE, wide_type'(99), '0);
      send_word(OP_PLACE, '0, '0);
      send_word(OP_PLACE, wide_type'(1), '0);
      send_word(OP_FREE, '0, DEFAULT_BYTES);
      send_word(OP_PLACE, wide_type'(10), '0);
      send_word(OP_FREE, '0, MAX_BYTES);
      send_word(OP_QUERY, MAX_BYTES, '0);
      send_word(OP_PLACE, wide_type'(1000), '0);
      send_word(OP_FREE, '0, wide_type'(1109));
      wait_for_responses();
   endtask

   // zero-size chunk at the very top of a full-width buffer reads as offset 0
   task automatic test_offset_at_top();
      write_buffer_size(TOP_BYTES);
      send_word(OP_FREE, '0, model_write_off);
      send_word(OP_PLACE, TOP_BYTES - model_write_off, '0);
      send_word(OP_PLACE, '0, '0);
      send_word(OP_FREE, '0, TOP_BYTES);
      send_word(OP_PLACE, wide_type'(5), '0);
      send_word(OP_FREE, '0, TOP_BYTES);
      wait_for_responses();
   endtask

   task automatic test_register_extremes();
      wide_type    sizes[3];
      int unsigned i;
      int unsigned n;
      sizes = '{'0, wide_type'(1), MAX_BYTES};
      for (i = 0; i < 3; i++) begin
         write_buffer_size(sizes[i]);
         for (n = 0; n < 12; n++)
            send_random_word();
         wait_for_responses();
      end
   endtask

   // new buffer size every hundred words
   task automatic test_random_traffic(int unsigned count);
      int unsigned n;
      for (n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            wait_for_responses();
            write_buffer_size(pick_buffer_size());
         end
         send_random_word();
      end
      wait_for_responses();
   endtask

   // receiver stalls long enough that the input side backs up
   task automatic test_input_backpressure();
      int unsigned n;
      rsp_hold_cycles = 300;
      for (n = 0; n < 40; n++)
         send_random_word();
      wait_for_responses();
   endtask

   // response side ready, with an optional long hold-off
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // compare each response word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            error_count++;
            $display("%0t: response word with nothing expected, granted %0d offset %0d wrapped %0d",
                     $time, rsp_granted, rsp_chunk_offset, rsp_wrapped);
         end else begin
            want_grant = expected_grants.pop_front();
            check_field("granted", 64'(want_grant.granted), 64'(rsp_granted));
            check_field("chunk_offset", 64'(want_grant.chunk_offset), 64'(rsp_chunk_offset));
            check_field("wrapped", 64'(want_grant.wrapped), 64'(rsp_wrapped));
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("** ring_chunk_allocator_top: FAILED **");
         $finish;
      end
   end

   initial begin
      req_idle_pct = 18;
      rsp_idle_pct = 72;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_fit_rules_at_reset();
      test_offset_at_top();
      test_register_extremes();
      test_random_traffic(400);
      req_idle_pct = 72;
      rsp_idle_pct = 18;
      test_random_traffic(400);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_input_backpressure();
      test_random_traffic(310);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("** ring_chunk_allocator_top: PASSED **");
      else
         $display("** ring_chunk_allocator_top: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rca_pkg.sv
rtl/rca_req_reg.sv
rtl/rca_core.sv
rtl/rca_rsp_reg.sv
rtl/ring_chunk_allocator_top.sv
bench/tb.sv
